// ===== rtl/msps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msps_pkg
// Shared types and constants of the servo PD slew controller.
// ----------------------------------------------------------------------------
package msps_pkg;

    localparam int CHANNELS_DEF = 4;
    localparam int FIELDS       = 4;

    localparam int ANGLE_W  = 16;
    localparam int ERR_W    = 17;
    localparam int GAIN_W   = 16;
    localparam int DRIVE_W  = 8;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = 4;

    localparam logic [ANGLE_W-1:0] ANGLE_MAX_Q   = 16'd46080;
    localparam logic [ANGLE_W-1:0] RESET_ANGLE_Q = 16'd23040;
    localparam logic [GAIN_W-1:0]  KP_RESET      = 16'd2458;
    localparam logic [GAIN_W-1:0]  KD_RESET      = 16'd205;
    localparam logic [GAIN_W-1:0]  LIMIT_RESET   = 16'd691;

    localparam logic [1:0] REG_KP    = 2'd0;
    localparam logic [1:0] REG_KD    = 2'd1;
    localparam logic [1:0] REG_LIMIT = 2'd2;

    typedef struct packed {
        logic [GAIN_W-1:0] kp;
        logic [GAIN_W-1:0] kd;
        logic [GAIN_W-1:0] limit;
    } t_cfg;

    typedef struct packed {
        logic [DRIVE_W-1:0] drive;
        logic               settled;
    } t_lane_res;

endpackage
`default_nettype wire

// ===== rtl/msps_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msps_cfg
// Register file for gains and step limit behind the APB-style port.
// ----------------------------------------------------------------------------
module msps_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [msps_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [msps_pkg::DATA_W-1:0]   pwdata,
    output logic      [msps_pkg::DATA_W-1:0]   prdata,
    output logic                               pready,
    output msps_pkg::t_cfg                     o_cfg
);
    import msps_pkg::*;

    logic [GAIN_W-1:0] r_kp;
    logic [GAIN_W-1:0] r_kd;
    logic [GAIN_W-1:0] r_limit;
    logic              w_wr;
    logic [1:0]        w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_idx  = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp    <= KP_RESET;
            r_kd    <= KD_RESET;
            r_limit <= LIMIT_RESET;
        end else if (w_wr) begin
            case (w_idx)
                REG_KP:    r_kp    <= pwdata[GAIN_W-1:0];
                REG_KD:    r_kd    <= pwdata[GAIN_W-1:0];
                REG_LIMIT: r_limit <= pwdata[GAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_KP:    prdata = {{(DATA_W-GAIN_W){1'b0}}, r_kp};
            REG_KD:    prdata = {{(DATA_W-GAIN_W){1'b0}}, r_kd};
            REG_LIMIT: prdata = {{(DATA_W-GAIN_W){1'b0}}, r_limit};
            default:   prdata = '0;
        endcase
    end

    assign o_cfg = '{kp: r_kp, kd: r_kd, limit: r_limit};

endmodule
`default_nettype wire

// ===== rtl/msps_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msps_lane
// One servo channel: PD step, slew saturation, angle clamp and channel state.
// ----------------------------------------------------------------------------
module msps_lane (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_en,
    input  wire logic [msps_pkg::DRIVE_W-1:0]   i_target,
    input  wire msps_pkg::t_cfg                 i_cfg,
    output msps_pkg::t_lane_res                 o_res
);
    import msps_pkg::*;

    logic        [ANGLE_W-1:0] r_angle;
    logic        [ERR_W-1:0]   r_prev_err;
    logic        [ANGLE_W-1:0] n_angle;

    logic signed [ERR_W-1:0]   w_err;
    logic signed [ERR_W:0]     w_der;
    logic signed [33:0]        w_p_term;
    logic signed [34:0]        w_d_term;
    logic signed [35:0]        w_acc;
    logic signed [23:0]        w_step;
    logic signed [23:0]        w_lim;
    logic signed [23:0]        w_step_sat;
    logic signed [23:0]        w_sum;

    assign w_err = $signed({1'b0, i_target, 8'h00}) - $signed({1'b0, r_angle});
    assign w_der = $signed({w_err[ERR_W-1], w_err})
                 - $signed({r_prev_err[ERR_W-1], r_prev_err});

    assign w_p_term = $signed({1'b0, i_cfg.kp}) * w_err;
    assign w_d_term = $signed({1'b0, i_cfg.kd}) * w_der;
    assign w_acc    = $signed({{2{w_p_term[33]}}, w_p_term})
                    + $signed({w_d_term[34], w_d_term}) + 36'sd2048;
    assign w_step   = w_acc[35:12];
    assign w_lim    = $signed({8'h00, i_cfg.limit});

    always_comb begin
        if (w_step > w_lim) begin
            w_step_sat = w_lim;
        end else if (w_step < -w_lim) begin
            w_step_sat = -w_lim;
        end else begin
            w_step_sat = w_step;
        end
        w_sum = $signed({8'h00, r_angle}) + w_step_sat;
        if (w_sum < 24'sd0) begin
            n_angle = '0;
        end else if (w_sum > $signed({8'h00, ANGLE_MAX_Q})) begin
            n_angle = ANGLE_MAX_Q;
        end else begin
            n_angle = w_sum[ANGLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle    <= RESET_ANGLE_Q;
            r_prev_err <= '0;
        end else if (i_en) begin
            r_angle    <= n_angle;
            r_prev_err <= w_err;
        end
    end

    assign o_res.drive   = n_angle[ANGLE_W-1:8];
    assign o_res.settled = (w_err <= 17'sd256) && (w_err >= -17'sd256);

endmodule
`default_nettype wire

// ===== rtl/msps_merge.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msps_merge
// Combine lane results into one result and hold it in an output register
// backed by a skid register.
// ----------------------------------------------------------------------------
module msps_merge (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_rst_n,
    input  wire logic                                      i_accept,
    input  wire msps_pkg::t_lane_res [msps_pkg::FIELDS-1:0] i_res,
    input  wire logic                                      i_stall,
    output logic                                           o_valid,
    output logic                                           o_full,
    output logic [msps_pkg::FIELDS-1:0][msps_pkg::DRIVE_W-1:0] o_drive,
    output logic                                           o_settled
);
    import msps_pkg::*;

    logic                              r_out_valid;
    logic                              r_skid_valid;
    logic [FIELDS-1:0][DRIVE_W-1:0]    r_out_drive;
    logic                              r_out_settled;
    logic [FIELDS-1:0][DRIVE_W-1:0]    r_skid_drive;
    logic                              r_skid_settled;
    logic [FIELDS-1:0][DRIVE_W-1:0]    w_drive;
    logic                              w_settled;
    logic                              w_take;

    always_comb begin
        w_settled = 1'b1;
        for (int i = 0; i < FIELDS; i++) begin
            w_drive[i] = i_res[i].drive;
            w_settled  = w_settled & i_res[i].settled;
        end
    end

    assign w_take = r_out_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_accept) begin
            if (r_out_valid && !w_take) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (w_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_take) begin
                r_out_drive   <= r_skid_drive;
                r_out_settled <= r_skid_settled;
            end
        end else if (i_accept) begin
            if (r_out_valid && !w_take) begin
                r_skid_drive   <= w_drive;
                r_skid_settled <= w_settled;
            end else begin
                r_out_drive   <= w_drive;
                r_out_settled <= w_settled;
            end
        end
    end

    assign o_valid   = r_out_valid;
    assign o_full    = r_skid_valid;
    assign o_drive   = r_out_drive;
    assign o_settled = r_out_settled;

`ifndef NO_ASSERTIONS
    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a request while output is empty");

    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_stall) |=> (r_out_valid && !r_skid_valid))
        else $error("skid did not drain into output");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && r_out_valid && i_stall) |=> r_skid_valid)
        else $error("request lost while output stalled");

    a_direct_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && !r_out_valid) |=> (r_out_valid && !r_skid_valid))
        else $error("request not loaded into empty output");
`endif

endmodule
`default_nettype wire

// ===== rtl/multi_servo_pd_slew_controller_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_servo_pd_slew_controller_core
// Per-tick PD servo update with slew limit for up to four channels.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_stall with one target per channel in whole
// degrees. Output channel: o_valid / i_stall with the integer drive angles
// and the settled flag. A request is taken when valid is high and stall low.
// Gains and the step limit must be written over the APB-style port only
// while idle; the block itself does not enforce this. pready is tied high
// and reads return the register value. Each lane updates its angle and last
// error in the cycle a request is taken, and the result is registered in
// the output register, or in the skid register if the output is held.
// One request per cycle is taken while o_stall is low; o_stall rises only
// while the skid register holds the one extra request kept on a stall.
// Synchronous reset sets every angle to 90 degrees, clears the last errors,
// loads the default gains and empties the output registers.
// ----------------------------------------------------------------------------
module multi_servo_pd_slew_controller_core #(
    parameter int CHANNELS = msps_pkg::CHANNELS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [msps_pkg::DRIVE_W-1:0]  i_target_a,
    input  wire logic [msps_pkg::DRIVE_W-1:0]  i_target_b,
    input  wire logic [msps_pkg::DRIVE_W-1:0]  i_target_c,
    input  wire logic [msps_pkg::DRIVE_W-1:0]  i_target_d,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic      [msps_pkg::DRIVE_W-1:0]  o_drive_a,
    output logic      [msps_pkg::DRIVE_W-1:0]  o_drive_b,
    output logic      [msps_pkg::DRIVE_W-1:0]  o_drive_c,
    output logic      [msps_pkg::DRIVE_W-1:0]  o_drive_d,
    output logic                               o_settled,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [msps_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [msps_pkg::DATA_W-1:0]   pwdata,
    output logic      [msps_pkg::DATA_W-1:0]   prdata,
    output logic                               pready
);
    import msps_pkg::*;

    localparam int LANES = (CHANNELS < FIELDS) ? CHANNELS : FIELDS;

    t_cfg                            w_cfg;
    t_lane_res [FIELDS-1:0]          w_res;
    logic [FIELDS-1:0][DRIVE_W-1:0]  w_target;
    logic [FIELDS-1:0][DRIVE_W-1:0]  w_drive;
    logic                            w_accept;
    logic                            w_full;

    assign w_target[0] = i_target_a;
    assign w_target[1] = i_target_b;
    assign w_target[2] = i_target_c;
    assign w_target[3] = i_target_d;

    assign w_accept = i_valid && !w_full;
    assign o_stall  = w_full;

    msps_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    for (genvar g = 0; g < FIELDS; g++) begin : g_lane
        if (g < LANES) begin : g_active
            msps_lane u_lane (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_en     (w_accept),
                .i_target (w_target[g]),
                .i_cfg    (w_cfg),
                .o_res    (w_res[g])
            );
        end else begin : g_idle
            assign w_res[g] = '{drive: '0, settled: 1'b1};
        end
    end

    msps_merge u_merge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (w_accept),
        .i_res     (w_res),
        .i_stall   (i_stall),
        .o_valid   (o_valid),
        .o_full    (w_full),
        .o_drive   (w_drive),
        .o_settled (o_settled)
    );

    assign o_drive_a = w_drive[0];
    assign o_drive_b = w_drive[1];
    assign o_drive_c = w_drive[2];
    assign o_drive_d = w_drive[3];

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the four-channel PD servo slew controller. A
// driver sends target ticks from a queue, a PD/slew predictor computes the
// expected drive angles and settled flag, and a monitor compares every
// result. Gains and the step limit are swept over the APB-style port
// between drained phases, with random idling, stalls and one long hold-off.
// ----------------------------------------------------------------------------
module tb_top;

    import msps_pkg::*;

    localparam int          CHANNELS     = CHANNELS_DEF;
    localparam int          LIMIT_CYCLES = 400000;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          IDLE_PCT     = 23;
    localparam int          MAX_REPORTS  = 10;
    localparam longint      ONE_DEG_Q    = 256;
    localparam longint      ROUND_HALF   = 2048;
    localparam logic [1:0]  REG_SPARE    = 2'd3;

    typedef struct packed {
        logic [DRIVE_W-1:0] a;
        logic [DRIVE_W-1:0] b;
        logic [DRIVE_W-1:0] c;
        logic [DRIVE_W-1:0] d;
    } servo_tick_t;

    typedef struct packed {
        logic [DRIVE_W-1:0] a;
        logic [DRIVE_W-1:0] b;
        logic [DRIVE_W-1:0] c;
        logic [DRIVE_W-1:0] d;
        logic               settled;
    } servo_drive_t;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_valid    = 1'b0;
    logic                 o_stall;
    logic [DRIVE_W-1:0]   i_target_a = '0;
    logic [DRIVE_W-1:0]   i_target_b = '0;
    logic [DRIVE_W-1:0]   i_target_c = '0;
    logic [DRIVE_W-1:0]   i_target_d = '0;
    logic                 o_valid;
    logic                 i_stall    = 1'b0;
    logic [DRIVE_W-1:0]   o_drive_a;
    logic [DRIVE_W-1:0]   o_drive_b;
    logic [DRIVE_W-1:0]   o_drive_c;
    logic [DRIVE_W-1:0]   o_drive_d;
    logic                 o_settled;
    logic                 psel       = 1'b0;
    logic                 penable    = 1'b0;
    logic                 pwrite     = 1'b0;
    logic [ADDR_W-1:0]    paddr      = '0;
    logic [DATA_W-1:0]    pwdata     = '0;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;

    servo_tick_t          tick_q[$];
    servo_drive_t         drive_exp_q[$];

    t_cfg                 gains;
    logic [ANGLE_W-1:0]   angle_q  [CHANNELS];
    logic signed [ERR_W-1:0] last_err [CHANNELS];

    bit                   quiet      = 1'b0;
    bit                   hold_armed = 1'b0;
    bit                   hold_used  = 1'b0;
    logic                 hold_off   = 1'b0;
    int                   hold_cnt   = 0;

    int                   mismatches   = 0;
    int                   ticks_sent   = 0;
    int                   drives_seen  = 0;
    int                   settled_seen = 0;
    int                   gain_sets    = 0;
    int                   cycle_cnt    = 0;

    multi_servo_pd_slew_controller_core #(
        .CHANNELS (CHANNELS)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_target_a (i_target_a),
        .i_target_b (i_target_b),
        .i_target_c (i_target_c),
        .i_target_d (i_target_d),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_drive_a  (o_drive_a),
        .o_drive_b  (o_drive_b),
        .o_drive_c  (o_drive_c),
        .o_drive_d  (o_drive_d),
        .o_settled  (o_settled),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("tb_top: timeout after %0d cycles", cycle_cnt);
            $display("[multi_servo_pd_slew_controller_core] ERROR");
            $finish;
        end
    end

    function automatic servo_drive_t pd_slew_update(servo_tick_t t);
        logic [DRIVE_W-1:0] tgt [FIELDS];
        logic [DRIVE_W-1:0] drv [FIELDS];
        longint             err;
        longint             der;
        longint             acc;
        longint             step;
        longint             lim;
        longint             nxt;
        logic               calm;
        servo_drive_t       r;
        tgt[0] = t.a;
        tgt[1] = t.b;
        tgt[2] = t.c;
        tgt[3] = t.d;
        calm = 1'b1;
        for (int i = 0; i < FIELDS; i++) begin
            drv[i] = '0;
            if (i < CHANNELS) begin
                err  = longint'({tgt[i], 8'h00}) - longint'(angle_q[i]);
                der  = err - longint'(last_err[i]);
                acc  = longint'(gains.kp) * err + longint'(gains.kd) * der;
                step = (acc + ROUND_HALF) >>> 12;
                lim  = longint'(gains.limit);
                if (step > lim)
                    step = lim;
                if (step < -lim)
                    step = -lim;
                nxt = longint'(angle_q[i]) + step;
                if (nxt < 0)
                    nxt = 0;
                if (nxt > longint'(ANGLE_MAX_Q))
                    nxt = longint'(ANGLE_MAX_Q);
                angle_q[i]  = nxt[ANGLE_W-1:0];
                last_err[i] = err[ERR_W-1:0];
                if (err > ONE_DEG_Q || err < -ONE_DEG_Q)
                    calm = 1'b0;
                drv[i] = angle_q[i][ANGLE_W-1:8];
            end
        end
        r.a       = drv[0];
        r.b       = drv[1];
        r.c       = drv[2];
        r.d       = drv[3];
        r.settled = calm;
        return r;
    endfunction

    // driver: advance to the next request once the current one is taken
    always @(posedge i_clk) begin : driver
        servo_tick_t t;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                angle_q[i]  = RESET_ANGLE_Q;
                last_err[i] = '0;
            end
        end else begin
            if (i_valid && !o_stall) begin
                drive_exp_q.push_back(pd_slew_update({i_target_a, i_target_b,
                                                      i_target_c, i_target_d}));
                ticks_sent++;
            end
            if (!i_valid || !o_stall) begin
                if (tick_q.size() != 0 &&
                    (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    t = tick_q.pop_front();
                    i_valid    <= 1'b1;
                    i_target_a <= t.a;
                    i_target_b <= t.b;
                    i_target_c <= t.c;
                    i_target_d <= t.d;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off so the block backs up into its input
    always @(posedge i_clk) begin
        if (hold_armed && !hold_used) begin
            hold_off  <= 1'b1;
            hold_cnt  <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            if (hold_cnt == 1)
                hold_off <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : monitor
        servo_drive_t got;
        servo_drive_t want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                got = {o_drive_a, o_drive_b, o_drive_c, o_drive_d, o_settled};
                drives_seen++;
                if (o_settled)
                    settled_seen++;
                if (drive_exp_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("tb_top: unexpected result a=%0d b=%0d c=%0d d=%0d s=%0b",
                                 got.a, got.b, got.c, got.d, got.settled);
                end else begin
                    want = drive_exp_q.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display({"tb_top: result %0d expected a=%0d b=%0d c=%0d d=%0d ",
                                      "s=%0b, got a=%0d b=%0d c=%0d d=%0d s=%0b"},
                                     drives_seen, want.a, want.b, want.c, want.d,
                                     want.settled, got.a, got.b, got.c, got.d,
                                     got.settled);
                    end
                end
            end
            i_stall <= hold_off || (!quiet && $urandom_range(0, 99) < IDLE_PCT);
        end
    end

    task automatic reg_write(input logic [1:0] idx, input logic [GAIN_W-1:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'($urandom), val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_KP:    gains.kp    = val;
            REG_KD:    gains.kd    = val;
            REG_LIMIT: gains.limit = val;
            default: ;
        endcase
    endtask

    task automatic reg_check(input logic [1:0] idx);
        logic [GAIN_W-1:0] want;
        case (idx)
            REG_KP:  want = gains.kp;
            REG_KD:  want = gains.kd;
            default: want = gains.limit;
        endcase
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        if (prdata[GAIN_W-1:0] !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("tb_top: register %0d expected %0d, got %0d",
                         idx, want, prdata[GAIN_W-1:0]);
        end
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_gains(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] kd,
                             input logic [GAIN_W-1:0] lim);
        reg_write(REG_KP, kp);
        reg_write(REG_KD, kd);
        reg_write(REG_LIMIT, lim);
        reg_write(REG_SPARE, 16'($urandom));
        reg_check(REG_KP);
        reg_check(REG_KD);
        reg_check(REG_LIMIT);
        gain_sets++;
    endtask

    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (tick_q.size() != 0 || i_valid || drive_exp_q.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [DRIVE_W-1:0] pick_target(logic [DRIVE_W-1:0] prev);
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return DRIVE_W'($urandom_range(0, 180));
        else if (r < 75)
            return DRIVE_W'($urandom_range(181, 255));
        else if (r < 85)
            return (r < 80) ? 8'd0 : 8'd180;
        return prev;
    endfunction

    // mostly held targets repeated for a random run length, with noise and nudges
    task automatic queue_moves(input int n);
        servo_tick_t t;
        int          left;
        int          r;
        int          len;
        t    = '{8'd90, 8'd90, 8'd90, 8'd90};
        left = n;
        while (left > 0) begin
            r = $urandom_range(0, 99);
            if (r < 75) begin
                t.a = pick_target(t.a);
                t.b = pick_target(t.b);
                t.c = pick_target(t.c);
                t.d = pick_target(t.d);
                len = $urandom_range(4, 45);
            end else if (r < 90) begin
                t   = servo_tick_t'($urandom);
                len = 1;
            end else begin
                t.a = t.a + DRIVE_W'($urandom_range(0, 2)) - 8'd1;
                t.b = t.b + DRIVE_W'($urandom_range(0, 2)) - 8'd1;
                t.c = t.c + DRIVE_W'($urandom_range(0, 2)) - 8'd1;
                t.d = t.d + DRIVE_W'($urandom_range(0, 2)) - 8'd1;
                len = $urandom_range(1, 6);
            end
            if (len > left)
                len = left;
            repeat (len) tick_q.push_back(t);
            left -= len;
        end
    endtask

    initial begin
        gains = '{KP_RESET, KD_RESET, LIMIT_RESET};
        i_rst_n = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        reg_check(REG_KP);
        reg_check(REG_KD);
        reg_check(REG_LIMIT);

        // directed ticks at reset gains: settled edges, extremes, bit patterns
        tick_q.push_back('{8'd90, 8'd90, 8'd90, 8'd90});
        tick_q.push_back('{8'd91, 8'd89, 8'd90, 8'd90});
        tick_q.push_back('{8'd92, 8'd90, 8'd90, 8'd88});
        tick_q.push_back('{8'd0, 8'd180, 8'd255, 8'd1});
        repeat (3) tick_q.push_back('{8'd255, 8'd255, 8'd255, 8'd255});
        repeat (3) tick_q.push_back('{8'd0, 8'd0, 8'd0, 8'd0});
        repeat (3) tick_q.push_back('{8'd180, 8'd180, 8'd180, 8'd180});
        tick_q.push_back('{8'd170, 8'd85, 8'd170, 8'd85});
        tick_q.push_back('{8'd85, 8'd170, 8'd85, 8'd170});
        tick_q.push_back('{8'd128, 8'd127, 8'd64, 8'd32});
        tick_q.push_back('{8'd16, 8'd8, 8'd4, 8'd2});
        wait_drained();

        queue_moves(500);
        wait_drained();

        set_gains(16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_moves(150);
        hold_armed = 1'b1;
        wait_drained();

        set_gains(16'd0, 16'd0, 16'd0);
        queue_moves(100);
        wait_drained();

        set_gains(16'd4096, 16'd0, ANGLE_MAX_Q);
        quiet = 1'b1;
        queue_moves(250);
        wait_drained();
        quiet = 1'b0;

        set_gains(GAIN_W'($urandom), GAIN_W'($urandom), GAIN_W'($urandom_range(0, 4000)));
        queue_moves(200);
        wait_drained();
        set_gains(GAIN_W'($urandom_range(0, 8192)), GAIN_W'($urandom_range(0, 2048)),
                  GAIN_W'($urandom_range(1, 2000)));
        queue_moves(200);
        wait_drained();

        set_gains(KP_RESET, KD_RESET, LIMIT_RESET);
        queue_moves(150);
        wait_drained();

        repeat (8) @(posedge i_clk);
        if (drive_exp_q.size() != 0) begin
            mismatches++;
            $display("tb_top: %0d expected results never arrived", drive_exp_q.size());
        end
        $display("tb_top: %0d servo ticks over %0d gain settings, %0d drive results (%0d settled)",
                 ticks_sent, gain_sets + 1, drives_seen, settled_seen);
        $display("tb_top: %0d mismatches", mismatches);
        if (mismatches == 0) begin
            $display("[multi_servo_pd_slew_controller_core] OK");
        end else begin
            $display("[multi_servo_pd_slew_controller_core] ERROR");
        end
        $finish;
    end

endmodule
